FILE: rtl/core/sgb_pkg.sv
// Shared types and constants for the separable Gaussian blur core.
// No dependencies.
package sgb_pkg;

	localparam logic [1:0] ACT_WEIGHT = 2'd0;
	localparam logic [1:0] ACT_PIXEL  = 2'd1;
	localparam logic [1:0] ACT_BLUR   = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COL,
		ST_ROW,
		ST_DRAIN,
		ST_HACC,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/core/separable_gaussian_blur_rgba8_core.sv
// Separable Gaussian blur core: frame store, tap table and blur sequencer.
// Depends on sgb_pkg and sgb_ram.
//
// Usage:
//  s_axis carries one item per beat: write a tap weight, write a pixel, or
//  request a blurred pixel. Only a blur request produces an m_axis beat.
//  Weight and pixel writes leave the core idle and can follow back to back.
//  A blur request at radius R walks 2R+1 columns. Each column fetches its
//  horizontal weight, reads 2R+1 pixels and weights from the one-port
//  stores (one read a cycle), drains the pipeline and takes one horizontal
//  multiply step. The core is ready for the next beat in the same cycle
//  that the result beat goes valid. The single frame store read port sets
//  the pace of the walk; weights come from a second one-port RAM read in
//  lockstep. Reset restores radius 5 and a 256 by 256 frame; both stores
//  hold garbage until written. The result waits in an output register;
//  while m_axis_tready is low the core still accepts the next beat but
//  holds a new blur result in its last step until the old one leaves.
//  Configuration writes are taken on any cycle with cfg_we high and
//  must only be issued while the core is idle.
module separable_gaussian_blur_rgba8_core
	import sgb_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action[1:0], x_pos[9:2], y_pos[17:10], tap_index[23:18], tap_weight[39:24],
	// in_red[47:40], in_green[55:48], in_blue[63:56], in_alpha[71:64]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
	output logic [31:0] m_axis_tdata
);
	localparam int SLOTS = 2 * MAX_RADIUS + 1;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int TW    = $clog2(SLOTS);
	localparam int CW    = 14;   // signed coord range for 8-bit pos +/- 25
	localparam int VW    = 24 + TW;        // vertical sum width per channel
	localparam int HW    = VW + 16 + TW;   // horizontal sum width per channel

	// Unpack the incoming beat.
	logic [1:0]  in_action;
	logic [7:0]  in_x, in_y;
	logic [5:0]  in_tap;
	logic [15:0] in_weight;
	logic [31:0] in_pixel;
	assign in_action = s_axis_tdata[1:0];
	assign in_x      = s_axis_tdata[9:2];
	assign in_y      = s_axis_tdata[17:10];
	assign in_tap    = s_axis_tdata[23:18];
	assign in_weight = s_axis_tdata[39:24];
	assign in_pixel  = s_axis_tdata[71:40];

	// Configuration registers.
	logic [4:0] radius_q;
	logic [8:0] width_q, height_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 5'd5;
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[4:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective radius and frame size, clamped to the build limits.
	logic [CW-1:0] rad_eff, w_eff, h_eff;
	always_comb begin
		rad_eff = (32'(radius_q) > MAX_RADIUS) ? CW'(MAX_RADIUS) : CW'(radius_q);
		if (width_q == 9'd0) w_eff = CW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(width_q);
		if (height_q == 9'd0) h_eff = CW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = CW'(MAX_HEIGHT);
		else h_eff = CW'(height_q);
	end

	// Sequencer state.
	state_t state_q, state_nx;
	logic [CW-1:0] x_q, y_q;
	logic [TW-1:0] s_q, r_q;       // column and row tap counters
	logic [TW-1:0] last_tap;
	logic          rd_vld_s1;      // a pixel/weight read is in flight
	logic          acc_vld_s2;     // read data registered, multiply next
	logic          vmul_vld_s3;
	logic [VW-1:0] vsum_q [4];
	logic [HW-1:0] hsum_q [4];
	logic [15:0]   hweight_q;
	logic [31:0]   res_q;
	logic          res_vld_q;
	logic [23:0]   vprod_s3 [4];

	assign last_tap = TW'(2 * rad_eff);

	// Store ports.
	logic          pix_we, wt_we;
	logic [AW-1:0] pix_addr;
	logic [TW-1:0] wt_addr;
	logic [31:0]   pix_rdata;
	logic [15:0]   wt_rdata;

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	// Clamped tap coordinates.
	logic signed [CW:0] cx, cy;
	logic [XW-1:0] cx_c;
	logic [YW-1:0] cy_c;
	always_comb begin
		cx = $signed({1'b0, x_q}) + $signed({1'b0, CW'(s_q)}) - $signed({1'b0, rad_eff});
		cy = $signed({1'b0, y_q}) + $signed({1'b0, CW'(r_q)}) - $signed({1'b0, rad_eff});
		if (cx < 0) cx_c = '0;
		else if (cx > $signed({1'b0, w_eff}) - 1) cx_c = XW'(w_eff - 1'b1);
		else cx_c = XW'(cx);
		if (cy < 0) cy_c = '0;
		else if (cy > $signed({1'b0, h_eff}) - 1) cy_c = YW'(h_eff - 1'b1);
		else cy_c = YW'(cy);
	end

	always_comb begin
		pix_we   = accept && in_action == ACT_PIXEL
			&& 32'(in_x) < MAX_WIDTH && 32'(in_y) < MAX_HEIGHT;
		wt_we    = accept && in_action == ACT_WEIGHT && 32'(in_tap) < SLOTS;
		pix_addr = AW'({cy_c, cx_c});
		wt_addr  = r_q;
		if (state_q == ST_IDLE) begin
			pix_addr = AW'({YW'(in_y), XW'(in_x)});
			wt_addr  = TW'(in_tap);
		end else if (state_q == ST_COL) begin
			wt_addr  = s_q;   // fetch the horizontal weight of this column
		end
	end

	sgb_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_pix (
		.clk(clk), .we(pix_we), .addr(pix_addr), .wdata(in_pixel), .rdata(pix_rdata)
	);
	sgb_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_wt (
		.clk(clk), .we(wt_we), .addr(wt_addr), .wdata(in_weight), .rdata(wt_rdata)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && in_action == ACT_BLUR) state_nx = ST_COL;
			ST_COL:   state_nx = ST_ROW;
			ST_ROW:   if (r_q == last_tap) state_nx = ST_DRAIN;
			ST_DRAIN: if (!rd_vld_s1 && !acc_vld_s2 && !vmul_vld_s3) state_nx = ST_HACC;
			ST_HACC:  state_nx = (s_q == last_tap) ? ST_OUT : ST_COL;
			ST_OUT:   if (!res_vld_q || m_axis_tready) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_vld_s1   <= 1'b0;
			acc_vld_s2  <= 1'b0;
			vmul_vld_s3 <= 1'b0;
			res_vld_q   <= 1'b0;
			s_q         <= '0;
			r_q         <= '0;
		end else begin
			state_q     <= state_nx;
			rd_vld_s1   <= (state_q == ST_ROW);
			acc_vld_s2  <= rd_vld_s1;
			vmul_vld_s3 <= acc_vld_s2;
			if (m_axis_tvalid && m_axis_tready) res_vld_q <= 1'b0;
			if (state_q == ST_OUT && state_nx == ST_IDLE) res_vld_q <= 1'b1;
			if (state_q == ST_IDLE) begin
				s_q <= '0;
				r_q <= '0;
			end else if (state_q == ST_ROW) begin
				r_q <= (r_q == last_tap) ? '0 : r_q + 1'b1;
			end else if (state_q == ST_HACC) begin
				s_q <= s_q + 1'b1;
			end
		end
	end

	// Datapath: one pixel times one weight per channel each cycle, then
	// accumulate; after a column, one horizontal multiply-accumulate.
	logic [31:0] pix_s2;
	logic [15:0] w_s2;
	logic [HW-1:0] hprod [4];
	always_ff @(posedge clk) begin
		if (accept && in_action == ACT_BLUR) begin
			x_q <= CW'(in_x);
			y_q <= CW'(in_y);
			for (int c = 0; c < 4; c++) hsum_q[c] <= '0;
		end
		if (state_q == ST_COL) begin
			for (int c = 0; c < 4; c++) vsum_q[c] <= '0;
		end
		if (state_q == ST_ROW && r_q == '0) hweight_q <= wt_rdata;
		pix_s2 <= pix_rdata;
		w_s2   <= wt_rdata;
		for (int c = 0; c < 4; c++) begin
			vprod_s3[c] <= w_s2 * pix_s2[8*c +: 8];
			if (vmul_vld_s3) vsum_q[c] <= vsum_q[c] + VW'(vprod_s3[c]);
			hprod[c] <= HW'(hweight_q) * HW'(vsum_q[c]);
		end
		if (state_q == ST_HACC) begin
			for (int c = 0; c < 4; c++) hsum_q[c] <= hsum_q[c] + hprod[c];
		end
		if (state_q == ST_OUT && state_nx == ST_IDLE) begin
			for (int c = 0; c < 4; c++)
				res_q[8*c +: 8] <= (hsum_q[c][HW-1:30] > (HW-30)'(255)) ? 8'hFF
					: hsum_q[c][37:30];
		end
	end

	assign m_axis_tvalid = res_vld_q;
	assign m_axis_tdata  = res_q;
endmodule

FILE: rtl/core/sgb_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module sgb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: rtl/core/sgb_checker.sv
// Port-level checker for the blur core, bound to the top level.
// Depends on sgb_pkg and the top-level ports.
module sgb_checker
	import sgb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [71:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	// A held result keeps its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// A blur request cannot finish in the next cycle.
	a_blur_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == ACT_BLUR |=> !s_axis_tready)
		else $error("ready during blur");
	// Writes never produce a result.
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != ACT_BLUR && !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("result after write");
endmodule

bind separable_gaussian_blur_rgba8_core sgb_checker u_sgb_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.s_axis_tdata(s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

FILE: tb/blur_checker.sv
// Scoreboard for the separable Gaussian blur core: tracks the frame store, tap table
// and register writes, predicts every blurred pixel and compares the result beats.
// Depends on sgb_pkg.
module blur_checker
	import sgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	output int          fail_count,
	output int          pending,
	output int          blurs_checked
);

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	logic [31:0] frame_copy [0:65535];
	logic [15:0] tap_copy [0:50];
	logic [4:0]  radius_q;
	logic [8:0]  width_q;
	logic [8:0]  height_q;
	rgba_t       awaited_pixels [$];

	function automatic int clamp_to(int v, int lim);
		if (v < 0) return 0;
		if (v > lim - 1) return lim - 1;
		return v;
	endfunction

	function automatic rgba_t blurred_pixel(int x, int y);
		longint unsigned sum [4];
		longint unsigned colsum [4];
		longint unsigned v;
		int rad, w, h, cx, cy;
		logic [31:0] px;
		rgba_t res;
		rad = (radius_q > 25) ? 25 : int'(radius_q);
		w = (width_q == 0) ? 1 : ((width_q > 256) ? 256 : int'(width_q));
		h = (height_q == 0) ? 1 : ((height_q > 256) ? 256 : int'(height_q));
		for (int c = 0; c < 4; c++) sum[c] = 0;
		for (int s = -rad; s <= rad; s++) begin
			cx = clamp_to(x + s, w);
			for (int c = 0; c < 4; c++) colsum[c] = 0;
			for (int r = -rad; r <= rad; r++) begin
				cy = clamp_to(y + r, h);
				px = frame_copy[cy * 256 + cx];
				for (int c = 0; c < 4; c++)
					colsum[c] += longint'(tap_copy[r + rad]) * longint'(px[8*c +: 8]);
			end
			for (int c = 0; c < 4; c++)
				sum[c] += longint'(tap_copy[s + rad]) * colsum[c];
		end
		for (int c = 0; c < 4; c++) begin
			v = sum[c] >> 30;
			res[8*c +: 8] = (v > 255) ? 8'd255 : v[7:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgba_t want, got;
		logic [1:0] act;
		logic [7:0] xp, yp;
		logic [5:0] slot;
		if (!arst_n) begin
			radius_q <= 5'd5;
			width_q <= 9'd256;
			height_q <= 9'd256;
			awaited_pixels.delete();
			fail_count <= 0;
			pending <= 0;
			blurs_checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS: radius_q <= cfg_data[4:0];
					REG_WIDTH: width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				act = s_axis_tdata[1:0];
				xp = s_axis_tdata[9:2];
				yp = s_axis_tdata[17:10];
				slot = s_axis_tdata[23:18];
				case (act)
					ACT_WEIGHT: if (slot <= 50) tap_copy[slot] = s_axis_tdata[39:24];
					ACT_PIXEL: frame_copy[{yp, xp}] = s_axis_tdata[71:40];
					ACT_BLUR: awaited_pixels.push_back(blurred_pixel(xp, yp));
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (awaited_pixels.size() == 0) begin
					$display("%0t: unexpected result beat %h, expected none", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited_pixels.pop_front();
					blurs_checked <= blurs_checked + 1;
					if (got != want) begin
						if (got.red != want.red)
							$display("%0t: red mismatch expected %0d actual %0d",
								$time, want.red, got.red);
						if (got.green != want.green)
							$display("%0t: green mismatch expected %0d actual %0d",
								$time, want.green, got.green);
						if (got.blue != want.blue)
							$display("%0t: blue mismatch expected %0d actual %0d",
								$time, want.blue, got.blue);
						if (got.alpha != want.alpha)
							$display("%0t: alpha mismatch expected %0d actual %0d",
								$time, want.alpha, got.alpha);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= awaited_pixels.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the blur core testbench: clock, reset, beat stimulus, register phases and verdict.
// Depends on sgb_pkg, blur_checker and separable_gaussian_blur_rgba8_core.
module testbench
	import sgb_pkg::*;
();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 230;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// action, x_pos, y_pos, tap_index, tap_weight, in_red, in_green, in_blue, in_alpha
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// out_red, out_green, out_blue, out_alpha
	logic [31:0] m_axis_tdata;

	int fail_count, pending, blurs_checked;
	int cycles = 0;
	int items_sent = 0;
	int settings_used = 0;
	bit quiet = 0;           // no gaps on either side while set
	bit want_hold = 0;

	// Local view of the registers and of which pixels hold data, so that no
	// request ever reads an unwritten pixel.
	int cur_radius = 5, cur_width = 256, cur_height = 256;
	bit pixel_known [0:65535];

	separable_gaussian_blur_rgba8_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	blur_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .pending(pending), .blurs_checked(blurs_checked)
	);

	always #2 clk = ~clk;

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: count result beats, then stall a random number of cycles after each.
	int rx_beats = 0;
	always @(posedge clk)
		if (m_axis_tvalid && m_axis_tready) rx_beats++;

	int rx_seen = 0, rx_wait = 0, hold_left = 0;
	bit hold_started = 0;
	always @(negedge clk) begin
		if (want_hold && !hold_started) begin
			hold_started = 1;
			hold_left = 400;
		end
		if (rx_beats != rx_seen) begin
			rx_seen = rx_beats;
			rx_wait = quiet ? 0 : $urandom_range(0, 7);
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Present one beat after a random gap and hold it until accepted.
	task automatic send_beat(logic [1:0] act, logic [7:0] x, logic [7:0] y,
			logic [5:0] slot, logic [15:0] weight, logic [31:0] px);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {px, weight, slot, y, x, act};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		if (act != ACT_UNUSED && !(act == ACT_WEIGHT && slot > 50)) items_sent++;
	endtask

	task automatic write_pixel(int x, int y, logic [31:0] px);
		send_beat(ACT_PIXEL, x[7:0], y[7:0], '0, '0, px);
		pixel_known[y * 256 + x] = 1;
	endtask

	function automatic int edge_clamp(int v, int lim);
		if (v < 0) return 0;
		if (v > lim - 1) return lim - 1;
		return v;
	endfunction

	// Fill any unwritten pixel under the blur window, then ask for the blur.
	task automatic request_blur(int x, int y);
		int rad, w, h, cx, cy;
		x = x & 255;   // the request carries 8-bit coordinates
		y = y & 255;
		rad = (cur_radius > 25) ? 25 : cur_radius;
		w = (cur_width == 0) ? 1 : ((cur_width > 256) ? 256 : cur_width);
		h = (cur_height == 0) ? 1 : ((cur_height > 256) ? 256 : cur_height);
		for (int s = -rad; s <= rad; s++)
			for (int r = -rad; r <= rad; r++) begin
				cx = edge_clamp(x + s, w);
				cy = edge_clamp(y + r, h);
				if (!pixel_known[cy * 256 + cx]) write_pixel(cx, cy, $urandom);
			end
		send_beat(ACT_BLUR, x[7:0], y[7:0], 6'($urandom), 16'($urandom), $urandom);
	endtask

	// Drain outstanding results, let trailing writes settle, then set all registers.
	task automatic set_registers(int rad, int w, int h);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_RADIUS;
		cfg_data <= 9'(rad);
		@(negedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data <= 9'(w);
		@(negedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= 9'(h);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_radius = rad;
		cur_width = w;
		cur_height = h;
		settings_used++;
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			send_beat(ACT_WEIGHT, 8'($urandom), 8'($urandom), 6'($urandom_range(0, 63)),
				16'($urandom), $urandom);
		else if (pick < 14)
			send_beat(ACT_UNUSED, 8'($urandom), 8'($urandom), 6'($urandom),
				16'($urandom), $urandom);
		else if (pick < 55)
			write_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
		else if (pick < 80)
			request_blur($urandom_range(0, cur_width > 1 ? cur_width - 1 : 0),
				$urandom_range(0, cur_height > 1 ? cur_height - 1 : 0));
		else
			request_blur($urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	function automatic int random_size();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 511;
			2: return 256;
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole tap table; one full-scale and one zero slot for saturation.
		for (int i = 0; i <= 50; i++)
			send_beat(ACT_WEIGHT, 8'($urandom), 8'($urandom), 6'(i),
				(i == 5) ? 16'hFFFF : ((i == 3) ? 16'h0000 : 16'($urandom_range(0, 8192))),
				$urandom);

		// Directed: ignored slot, unused action, extreme pixels, corner requests.
		send_beat(ACT_WEIGHT, '0, '0, 6'd63, 16'h1234, '0);
		send_beat(ACT_UNUSED, 8'hFF, 8'hFF, 6'h3F, 16'hFFFF, 32'hFFFFFFFF);
		write_pixel(0, 0, 32'h00000000);
		write_pixel(255, 255, 32'hFFFFFFFF);
		write_pixel(255, 0, 32'hFF00FF00);
		request_blur(0, 0);

		set_registers(0, 256, 256);          // single tap: copies pixel times weight squared
		request_blur(255, 255);
		request_blur(255, 0);
		set_registers(31, 3, 2);             // radius saturates, tiny frame
		request_blur(200, 100);
		request_blur(1, 1);
		set_registers(25, 0, 511);           // zero width acts as one, height saturates
		request_blur(0, 0);
		request_blur(0, 255);

		// Pressure: receiver holds off while many short blurs queue up.
		set_registers(1, 4, 4);
		for (int y = 0; y < 4; y++)
			for (int x = 0; x < 4; x++) write_pixel(x, y, $urandom);
		quiet = 1;
		want_hold = 1;
		for (int i = 0; i < 12; i++) request_blur($urandom_range(0, 3), $urandom_range(0, 3));
		quiet = 0;

		// Random phases with small radii; one of them without any gaps.
		for (int ph = 0; ph < 4 && items_sent < ITEM_TARGET; ph++) begin
			set_registers($urandom_range(0, 2), random_size(), random_size());
			quiet = (ph == 1);
			for (int n = 0; n < 15 && items_sent < ITEM_TARGET; n++) random_item();
			quiet = 0;
		end
		while (items_sent < ITEM_TARGET) random_item();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (3000) @(posedge clk);

		$display("Run covered %0d input beats and %0d checked blur results", items_sent,
			blurs_checked);
		$display("across %0d register settings, including saturated and zero sizes",
			settings_used);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: separable_gaussian_blur_rgba8_core.f
rtl/core/sgb_pkg.sv
rtl/core/sgb_ram.sv
rtl/core/separable_gaussian_blur_rgba8_core.sv
rtl/core/sgb_checker.sv
tb/blur_checker.sv
tb/testbench.sv
